[rtl/iqunp_pkg.sv]
// Shared types, constants and decode helpers for the I/Q sample word unpacker.
// Used by every module of the block; depends on nothing.
package iqunp_pkg;

    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BPC   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANS = 8'd1;

    // Quantization widths.
    localparam logic [1:0] BPC_NONE  = 2'd0;
    localparam logic [1:0] BPC_ONE   = 2'd1;
    localparam logic [1:0] BPC_TWO   = 2'd2;
    localparam logic [1:0] BPC_THREE = 2'd3;

    // Sample times per word, indexed by bits_per_component * channel_count (1 to 32).
    localparam logic [5:0] TIMES_LUT [0:32] = '{
        6'd0,  6'd32, 6'd16, 6'd10, 6'd8,  6'd6,  6'd5,  6'd4,  6'd4,  6'd3,  6'd3,
        6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
        6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,
        6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1
    };

    // One aligned word waiting to be unpacked.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [5:0]        total;
        logic [1:0]        bpc;
        logic [5:0]        chans;
    } entry_t;

    // A code with its top bit clear maps to code + 1, otherwise to code - 2^q.
    function automatic logic signed [3:0] decode_code(logic [2:0] code, logic [1:0] bpc);
        logic       top;
        logic [3:0] full;
        logic [3:0] wide;
        case (bpc)
            BPC_ONE: top = code[0];
            BPC_TWO: top = code[1];
            default: top = code[2];
        endcase
        full = 4'd1 << bpc;
        wide = {1'b0, code};
        if (!top)
        begin
            return signed'(wide + 4'd1);
        end
        return signed'(wide - full);
    endfunction

endpackage

[rtl/iq_sample_word_unpack.sv]
// Accepted words are queued, then unpacked by the back part into registered results.
// Throughput: one result per cycle from the back sequencer while the output is not
// stalled, up to 32 results per word; words that yield no result are not queued.
// The queue lets the next word be accepted while the current one is still unpacked.
// Reset: asynchronous, active low; registers return to one bit and one channel,
// and no word is accepted in the first cycle after reset or after a register write.
module iq_sample_word_unpack
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [63:0]                         s_axis_tdata,   // raw_word[63:0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // i_value[3:0], q_value[7:4], channel_index[12:8], time_index[17:13], zeros[23:18]
    output logic [23:0]                         m_axis_tdata,
    output logic                                m_axis_tlast,   // last_of_word
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iqunp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iqunp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    iqunp_pkg::entry_t push_entry;
    iqunp_pkg::entry_t pop_entry;
    logic              push;
    logic              queue_full;
    logic              pop;
    logic              pop_valid;
    logic [3:0]        out_i;
    logic [3:0]        out_q;
    logic [4:0]        out_chan;
    logic [4:0]        out_time;

    iqunp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (s_axis_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    iqunp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_entry)
    );

    iqunp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ent_valid (pop_valid),
        .ent       (pop_entry),
        .ent_pop   (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_i     (out_i),
        .out_q     (out_q),
        .out_chan  (out_chan),
        .out_time  (out_time),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_time, out_chan, out_q, out_i};

    // Decoded sample values are never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] != 4'd0) && (m_axis_tdata[7:4] != 4'd0))
        else $error("decoded sample value is zero");

    // The result after the last one of a word opens a new word at its first position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
        (!m_axis_tvalid || (m_axis_tdata[17:8] == 10'd0)))
        else $error("new word does not start at time zero, channel zero");

    // A transfer that is not the last of its word is followed by another result of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        !(m_axis_tvalid && (m_axis_tdata[17:8] == 10'd0)))
        else $error("word restarted before its last result");

endmodule

[rtl/iqunp_front.sv]
// Front part of the unpacker: configuration registers, per-word layout and alignment.
// Depends on iqunp_pkg; feeds aligned words into the queue.
module iqunp_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iqunp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iqunp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [iqunp_pkg::WORD_W-1:0]        in_word,
    input  logic                                queue_full,
    output logic                                push,
    output iqunp_pkg::entry_t                   push_entry
);

    logic [1:0]  bpc_reg;
    logic [5:0]  chans_reg;
    logic        pend_reg;
    logic        ok_reg;
    logic [5:0]  total_reg;
    logic [5:0]  spare_reg;

    logic [7:0]  prod_next;
    logic        ok_next;
    logic [5:0]  times_next;
    logic [11:0] total_wide;
    logic [5:0]  total_next;
    logic [6:0]  used_next;
    logic [6:0]  spare_wide;
    logic [5:0]  spare_next;
    logic        cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Layout of one word: how many results it yields and how many spare bits lead it.
    always_comb
    begin
        prod_next  = 8'({6'd0, bpc_reg} * {2'd0, chans_reg});
        ok_next    = (bpc_reg != iqunp_pkg::BPC_NONE) && (chans_reg != 6'd0)
                     && (prod_next <= 8'd32);
        times_next = ok_next ? iqunp_pkg::TIMES_LUT[prod_next[5:0]] : 6'd0;
        total_wide = times_next * chans_reg;
        total_next = total_wide[5:0];
        used_next  = 7'({1'b0, total_next} * {bpc_reg, 1'b0});
        spare_wide = 7'd64 - used_next;
        spare_next = spare_wide[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpc_reg   <= iqunp_pkg::BPC_ONE;
            chans_reg <= 6'd1;
            pend_reg  <= 1'b1;
        end
        else
        begin
            pend_reg <= cfg_fire;
            if (cfg_fire)
            begin
                if (cfg_index == iqunp_pkg::CFG_BPC)
                begin
                    bpc_reg <= cfg_data[1:0];
                end
                else if (cfg_index == iqunp_pkg::CFG_CHANS)
                begin
                    chans_reg <= cfg_data[5:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        total_reg <= total_next;
        spare_reg <= spare_next;
    end

    // The layout registers settle in the cycle after a configuration write.
    assign in_ready = !queue_full && !pend_reg;
    assign push     = in_valid && in_ready && ok_reg;

    always_comb
    begin
        push_entry.word  = in_word << spare_reg;
        push_entry.total = total_reg;
        push_entry.bpc   = bpc_reg;
        push_entry.chans = chans_reg;
    end

endmodule

[rtl/iqunp_fifo.sv]
// Short first-word-fall-through queue between the front and back parts.
// Depends on iqunp_pkg for the entry type.
module iqunp_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  iqunp_pkg::entry_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output iqunp_pkg::entry_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    iqunp_pkg::entry_t mem [0:DEPTH-1];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/iqunp_back.sv]
// Back part of the unpacker: walks one aligned word from the top, one result per cycle
// unless the output stalls. Depends on iqunp_pkg; drives the registered result stream.
module iqunp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ent_valid,
    input  iqunp_pkg::entry_t ent,
    output logic              ent_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        out_i,
    output logic [3:0]        out_q,
    output logic [4:0]        out_chan,
    output logic [4:0]        out_time,
    output logic              out_last
);

    logic        act_reg;
    logic        ov_reg;
    logic [63:0] sh_reg;
    logic [5:0]  rem_reg;
    logic [4:0]  ch_reg;
    logic [4:0]  tm_reg;
    logic [1:0]  bpc_reg;
    logic [5:0]  chans_reg;
    logic [3:0]  oi_reg;
    logic [3:0]  oq_reg;
    logic [4:0]  och_reg;
    logic [4:0]  otm_reg;
    logic        olast_reg;

    logic        act_next;
    logic        ov_next;
    logic [63:0] sh_next;
    logic [5:0]  rem_next;
    logic [4:0]  ch_next;
    logic [4:0]  tm_next;
    logic [1:0]  bpc_next;
    logic [5:0]  chans_next;
    logic [3:0]  oi_next;
    logic [3:0]  oq_next;
    logic [4:0]  och_next;
    logic [4:0]  otm_next;
    logic        olast_next;

    logic        adv;
    logic        finishing;
    logic [2:0]  icode;
    logic [2:0]  qcode;
    logic [63:0] sh_step;
    logic [5:0]  ch_last_wide;

    always_comb
    begin
        adv          = act_reg && (!ov_reg || out_ready);
        finishing    = adv && (rem_reg == 6'd1);
        ent_pop      = ent_valid && (!act_reg || finishing);
        ch_last_wide = chans_reg - 6'd1;

        case (bpc_reg)
            iqunp_pkg::BPC_ONE:
            begin
                icode   = {2'd0, sh_reg[63]};
                qcode   = {2'd0, sh_reg[62]};
                sh_step = sh_reg << 2;
            end
            iqunp_pkg::BPC_TWO:
            begin
                icode   = {1'b0, sh_reg[63:62]};
                qcode   = {1'b0, sh_reg[61:60]};
                sh_step = sh_reg << 4;
            end
            default:
            begin
                icode   = sh_reg[63:61];
                qcode   = sh_reg[60:58];
                sh_step = sh_reg << 6;
            end
        endcase

        act_next   = act_reg;
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        ch_next    = ch_reg;
        tm_next    = tm_reg;
        bpc_next   = bpc_reg;
        chans_next = chans_reg;
        oi_next    = oi_reg;
        oq_next    = oq_reg;
        och_next   = och_reg;
        otm_next   = otm_reg;
        olast_next = olast_reg;
        ov_next    = out_ready ? 1'b0 : ov_reg;

        if (adv)
        begin
            ov_next    = 1'b1;
            oi_next    = iqunp_pkg::decode_code(icode, bpc_reg);
            oq_next    = iqunp_pkg::decode_code(qcode, bpc_reg);
            och_next   = ch_reg;
            otm_next   = tm_reg;
            olast_next = (rem_reg == 6'd1);
            sh_next    = sh_step;
            rem_next   = rem_reg - 6'd1;
            if (ch_reg == ch_last_wide[4:0])
            begin
                ch_next = 5'd0;
                tm_next = tm_reg + 5'd1;
            end
            else
            begin
                ch_next = ch_reg + 5'd1;
            end
            if (finishing)
            begin
                act_next = 1'b0;
            end
        end

        if (ent_pop)
        begin
            act_next   = 1'b1;
            sh_next    = ent.word;
            rem_next   = ent.total;
            ch_next    = 5'd0;
            tm_next    = 5'd0;
            bpc_next   = ent.bpc;
            chans_next = ent.chans;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg    <= sh_next;
        rem_reg   <= rem_next;
        ch_reg    <= ch_next;
        tm_reg    <= tm_next;
        bpc_reg   <= bpc_next;
        chans_reg <= chans_next;
        oi_reg    <= oi_next;
        oq_reg    <= oq_next;
        och_reg   <= och_next;
        otm_reg   <= otm_next;
        olast_reg <= olast_next;
    end

    assign out_valid = ov_reg;
    assign out_i     = oi_reg;
    assign out_q     = oq_reg;
    assign out_chan  = och_reg;
    assign out_time  = otm_reg;
    assign out_last  = olast_reg;

endmodule

[tb/tb_iq_sample_word_unpack.sv]
// Self-checking testbench for iq_sample_word_unpack: directed table, then random words
// under several idling phases, every result checked by an unpack predictor or a row value.
// Depends on rtl/iqunp_pkg.sv and rtl/iq_sample_word_unpack.sv.
module tb_iq_sample_word_unpack;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int LONG_HOLD      = 300;
    localparam int PHASES         = 4;
    localparam int SEGMENTS       = 4;
    localparam int SEGMENT_WORDS  = 25;
    localparam int PRESSURE_WORDS = 12;
    localparam int DIR_ROWS       = 23;

    localparam logic [iqunp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [iqunp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

    localparam logic [63:0]        ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic signed [3:0]  PLUS_ONE  = 4'sd1;
    localparam logic signed [3:0]  MINUS_ONE = -4'sd1;

    localparam int SEND_IDLE [PHASES]  = '{0, 45, 0, 37};
    localparam int RECV_STALL [PHASES] = '{0, 0, 45, 37};

    typedef enum logic [1:0]
    {
        CHECK_MODEL,
        CHECK_NONE,
        CHECK_UNIFORM
    } check_kind_t;

    typedef struct packed
    {
        logic signed [3:0] i_val;
        logic signed [3:0] q_val;
        logic [4:0]        chan;
        logic [4:0]        tidx;
        logic              last;
    } iq_sample_t;

    typedef struct
    {
        check_kind_t       kind;
        logic signed [3:0] value;
        int                n_times;
    } word_check_t;

    typedef struct
    {
        int                bpc;
        int                chans;
        logic [63:0]       word;
        check_kind_t       kind;
        logic signed [3:0] value;
        int                n_times;
        bit                junk_write;
    } dir_row_t;

    // In uniform rows every sample of the word decodes to the same value, in packing order.
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{1, 1,  64'h0,                   CHECK_UNIFORM, PLUS_ONE,  32, 1'b0},
        '{1, 1,  ALL_ONES,                CHECK_UNIFORM, MINUS_ONE, 32, 1'b0},
        '{1, 1,  64'hAAAA_5555_0F0F_F0F0, CHECK_MODEL,   PLUS_ONE,  0,  1'b0},
        '{2, 1,  64'h0,                   CHECK_UNIFORM, PLUS_ONE,  16, 1'b0},
        '{2, 1,  ALL_ONES,                CHECK_UNIFORM, MINUS_ONE, 16, 1'b0},
        '{2, 1,  64'h0123_4567_89AB_CDEF, CHECK_MODEL,   PLUS_ONE,  0,  1'b0},
        '{3, 1,  64'h0,                   CHECK_UNIFORM, PLUS_ONE,  10, 1'b0},
        '{3, 1,  ALL_ONES,                CHECK_UNIFORM, MINUS_ONE, 10, 1'b0},
        '{3, 1,  64'h0539_77BB_E4F1_2680, CHECK_MODEL,   PLUS_ONE,  0,  1'b0},
        '{3, 1,  64'hFAC6_88D1_3E57_9B20, CHECK_MODEL,   PLUS_ONE,  0,  1'b1},
        '{1, 5,  64'hF000_0000_0000_0000, CHECK_UNIFORM, PLUS_ONE,  6,  1'b0},
        '{2, 3,  64'hDEAD_BEEF_CAFE_F00D, CHECK_MODEL,   PLUS_ONE,  0,  1'b0},
        '{3, 5,  64'h1234_5678_9ABC_DEF0, CHECK_MODEL,   PLUS_ONE,  0,  1'b0},
        '{3, 10, ALL_ONES,                CHECK_UNIFORM, MINUS_ONE, 1,  1'b0},
        '{3, 10, 64'h0FED_CBA9_8765_4321, CHECK_MODEL,   PLUS_ONE,  0,  1'b0},
        '{3, 11, ALL_ONES,                CHECK_NONE,    PLUS_ONE,  0,  1'b0},
        '{2, 16, 64'h0,                   CHECK_UNIFORM, PLUS_ONE,  1,  1'b0},
        '{2, 16, 64'h9E37_79B9_7F4A_7C15, CHECK_MODEL,   PLUS_ONE,  0,  1'b0},
        '{2, 17, 64'h5A5A_5A5A_A5A5_A5A5, CHECK_NONE,    PLUS_ONE,  0,  1'b0},
        '{1, 32, ALL_ONES,                CHECK_UNIFORM, MINUS_ONE, 1,  1'b0},
        '{1, 32, 64'h5555_5555_5555_5555, CHECK_MODEL,   PLUS_ONE,  0,  1'b0},
        '{1, 0,  ALL_ONES,                CHECK_NONE,    PLUS_ONE,  0,  1'b0},
        '{1, 32, 64'h8000_0000_0000_0001, CHECK_MODEL,   PLUS_ONE,  0,  1'b1}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [iqunp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [iqunp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [1:0]  bpc_cfg = iqunp_pkg::BPC_ONE;
    logic [5:0]  chans_cfg = 6'd1;
    int          drv_bpc = 1;
    int          drv_chans = 1;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          mismatch_count = 0;

    iq_sample_t  expected_samples [$];
    word_check_t word_checks [$];

    iq_sample_word_unpack dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [3:0] code_value(input logic [2:0] code, input int q);
        if (int'(code) < (1 << (q - 1)))
        begin
            return 4'(int'(code) + 1);
        end
        return 4'(int'(code) - (1 << q));
    endfunction

    function automatic void unpack_word(input logic [63:0] word);
        int          q;
        int          chans;
        int          per_time;
        int          times;
        int          spare;
        int          off;
        int          total;
        int          n;
        logic [63:0] shifted;
        logic [2:0]  mask;
        logic [2:0]  i_code;
        logic [2:0]  q_code;
        iq_sample_t  s;
        q = int'(bpc_cfg);
        chans = int'(chans_cfg);
        if (q == 0 || chans == 0 || q * chans > 32)
        begin
            return;
        end
        per_time = 2 * q * chans;
        times = 64 / per_time;
        spare = 64 - times * per_time;
        total = times * chans;
        n = 0;
        mask = 3'((1 << q) - 1);
        for (int t = 0; t < times; t++)
        begin
            for (int c = 0; c < chans; c++)
            begin
                off = spare + t * per_time + c * 2 * q;
                shifted = word >> (64 - off - q);
                i_code = shifted[2:0] & mask;
                shifted = word >> (64 - off - 2 * q);
                q_code = shifted[2:0] & mask;
                n++;
                s.i_val = code_value(i_code, q);
                s.q_val = code_value(q_code, q);
                s.chan = 5'(c);
                s.tidx = 5'(t);
                s.last = (n == total);
                expected_samples.push_back(s);
            end
        end
    endfunction

    function automatic logic [63:0] random_word();
        case ($urandom_range(15))
            0:       return 64'h0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(input logic [63:0] word, input check_kind_t kind,
                             input logic signed [3:0] value, input int n_times);
        word_check_t chk;
        chk.kind = kind;
        chk.value = value;
        chk.n_times = n_times;
        word_checks.push_back(chk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [iqunp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [iqunp_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (word_checks.size() != 0 || expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Waits until every accepted word has delivered its results, then idles before going on.
    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input int bpc, input int chans);
        settle();
        if ($urandom_range(1) == 0)
        begin
            write_reg(iqunp_pkg::CFG_BPC, 8'(bpc));
            write_reg(iqunp_pkg::CFG_CHANS, 8'(chans));
        end
        else
        begin
            write_reg(iqunp_pkg::CFG_CHANS, 8'(chans));
            write_reg(iqunp_pkg::CFG_BPC, 8'(bpc));
        end
        drv_bpc = bpc;
        drv_chans = chans;
    endtask

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        word_check_t chk;
        iq_sample_t  want;
        iq_sample_t  u;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    iqunp_pkg::CFG_BPC:   bpc_cfg = cfg_data[1:0];
                    iqunp_pkg::CFG_CHANS: chans_cfg = cfg_data[5:0];
                    default:   ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                chk = word_checks.pop_front();
                case (chk.kind)
                    CHECK_MODEL:
                    begin
                        unpack_word(s_axis_tdata);
                    end
                    CHECK_UNIFORM:
                    begin
                        for (int t = 0; t < chk.n_times; t++)
                        begin
                            for (int c = 0; c < int'(chans_cfg); c++)
                            begin
                                u.i_val = chk.value;
                                u.q_val = chk.value;
                                u.chan = 5'(c);
                                u.tidx = 5'(t);
                                u.last = (t == chk.n_times - 1) && (c == int'(chans_cfg) - 1);
                                expected_samples.push_back(u);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected result: tdata=%h tlast=%b", m_axis_tdata,
                                 m_axis_tlast);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (m_axis_tdata !== {6'd0, want.tidx, want.chan, want.q_val, want.i_val}
                        || m_axis_tlast !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch: expected i=%0d q=%0d ch=%0d t=%0d last=%b",
                                     want.i_val, want.q_val, want.chan, want.tidx, want.last);
                            $display("          got i=%0d q=%0d ch=%0d t=%0d last=%b pad=%h",
                                     $signed(m_axis_tdata[3:0]), $signed(m_axis_tdata[7:4]),
                                     m_axis_tdata[12:8], m_axis_tdata[17:13], m_axis_tlast,
                                     m_axis_tdata[23:18]);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL iq_sample_word_unpack");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int bpc;
        int chans;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].bpc != drv_bpc || dir_rows[r].chans != drv_chans)
            begin
                apply_config(dir_rows[r].bpc, dir_rows[r].chans);
            end
            if (dir_rows[r].junk_write)
            begin
                settle();
                write_reg(CFG_UNUSED_LO, 8'd2);
                write_reg(CFG_UNUSED_HI, 8'h3F);
            end
            send_word(dir_rows[r].word, dir_rows[r].kind, dir_rows[r].value,
                      dir_rows[r].n_times);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            if (p == 0)
            begin
                // Output held off while full-length words keep coming, so the input stalls.
                settle();
                hold_request = LONG_HOLD;
                apply_config(1, 1);
                for (int k = 0; k < PRESSURE_WORDS; k++)
                begin
                    send_word(random_word(), CHECK_MODEL, PLUS_ONE, 0);
                end
            end
            for (int s = 0; s < SEGMENTS; s++)
            begin
                bpc = $urandom_range(1, 3);
                case ($urandom_range(7))
                    0:       chans = 1;
                    1:       chans = 32 / bpc;
                    2:       chans = (bpc == 1) ? 32 : 32 / bpc + 1;
                    default: chans = $urandom_range(1, 32 / bpc);
                endcase
                apply_config(bpc, chans);
                for (int k = 0; k < SEGMENT_WORDS; k++)
                begin
                    if (p == 1 && k == SEGMENT_WORDS / 2)
                    begin
                        wait_for_results();
                    end
                    send_word(random_word(), CHECK_MODEL, PLUS_ONE, 0);
                end
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_samples.size() == 0)
        begin
            $display("PASS iq_sample_word_unpack");
        end
        else
        begin
            $display("FAIL iq_sample_word_unpack");
        end
        $finish;
    end

endmodule

[iq_sample_word_unpack.f]
rtl/iqunp_pkg.sv
rtl/iqunp_front.sv
rtl/iqunp_fifo.sv
rtl/iqunp_back.sv
rtl/iq_sample_word_unpack.sv
tb/tb_iq_sample_word_unpack.sv
